### rtl/tqa_pkg.sv
// ----------------------------------------------------------------------------
// tqa_pkg
// Shared widths, constants and interface types for the triangle quality
// averager and its arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package tqa_pkg;

    // Input and counter widths
    localparam int COORD_BITS = 20;
    localparam int COUNT_BITS = 20;

    // Shared multiplier: one half-operand product per issue
    localparam int HALF_W = 24;
    localparam int OPD_W  = 2 * HALF_W;
    localparam int PROD_W = 2 * HALF_W;

    // Shared add/subtract unit and its accumulator
    localparam int ACC_W = 96;

    // Datapath widths
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int EDGE_W = 22;
    localparam int FACT_W = 24;
    localparam int REM_W  = 65;
    localparam int RES_W  = 48;
    localparam int LOW_W  = 17;
    localparam int NUM_W  = 66;
    localparam int DEN_W  = 64;
    localparam int AREA_W = 43;
    localparam int AVG_W  = 17;
    localparam int RTOT_W = 40;
    localparam int WTOT_W = 64;
    localparam int ATOT_W = 64;
    localparam int CNT_W  = 6;

    // Iteration counts of the shared unit
    localparam logic [CNT_W-1:0] EDGE_ROOT_STEPS = 6'd21;
    localparam logic [CNT_W-1:0] AREA_ROOT_STEPS = 6'd45;
    localparam logic [CNT_W-1:0] DIV_STEPS       = 6'd17;

    // 1.0 in Q1.16
    localparam logic [AVG_W-1:0] RATIO_ONE = 17'd65536;

    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic             sub;
    } addsub_req_t;

    typedef struct packed {
        logic [ACC_W-1:0] sum;
        logic             borrow;
    } addsub_rsp_t;

endpackage

`default_nettype wire

### rtl/tqa_mul.sv
// ----------------------------------------------------------------------------
// tqa_mul
// Shared unsigned half-width multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module tqa_mul (
    input  logic                       clk,
    input  logic [tqa_pkg::HALF_W-1:0] x,
    input  logic [tqa_pkg::HALF_W-1:0] y,
    output logic [tqa_pkg::PROD_W-1:0] prod_reg
);
    import tqa_pkg::*;

    logic [PROD_W-1:0] prod_next;

    // Product, registered for the accumulate step
    assign prod_next = x * y;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

### rtl/tqa_addsub.sv
// ----------------------------------------------------------------------------
// tqa_addsub
// Shared wide add / subtract-compare unit used by accumulate, root and divide.
// ----------------------------------------------------------------------------
`default_nettype none

module tqa_addsub (
    input  tqa_pkg::addsub_req_t req,
    output tqa_pkg::addsub_rsp_t rsp
);
    import tqa_pkg::*;

    logic [ACC_W:0]   full;
    logic [ACC_W-1:0] b_op;

    // Subtract as a + ~b + 1; borrow when no carry out
    assign b_op = req.sub ? ~req.b : req.b;
    assign full = {1'b0, req.a} + {1'b0, b_op} + {{ACC_W{1'b0}}, req.sub};

    assign rsp.sum    = full[ACC_W-1:0];
    assign rsp.borrow = req.sub & ~full[ACC_W];

endmodule

`default_nettype wire

### rtl/triangle_quality_averager.sv
// ----------------------------------------------------------------------------
// triangle_quality_averager
// Per-triangle edge lengths, Heron area and radius ratio, accumulated into
// mesh statistics; the last triangle emits the means and clears the totals.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid / in_stall    | ax..cz, last_triangle
//  out     | output    | out_valid / out_stall  | avg_ratio .. saturated
//
//  One triangle is worked through by the sequencer running one 24x24
//  multiplier and one 96-bit add/subtract unit, one bit per cycle for roots
//  and divides; the ratio and area steps are skipped when the Heron factors
//  are not all positive, and the last triangle adds up to two divides.
//  in_stall is low only while the sequencer is idle. A result waits in the
//  output register under out_stall while the next triangle is taken.
//  Reset clears the totals, the sequencer and out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_quality_averager (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [tqa_pkg::COORD_BITS-1:0] ax,
    input  logic signed [tqa_pkg::COORD_BITS-1:0] ay,
    input  logic signed [tqa_pkg::COORD_BITS-1:0] az,
    input  logic signed [tqa_pkg::COORD_BITS-1:0] bx,
    input  logic signed [tqa_pkg::COORD_BITS-1:0] by_coord,
    input  logic signed [tqa_pkg::COORD_BITS-1:0] bz,
    input  logic signed [tqa_pkg::COORD_BITS-1:0] cx,
    input  logic signed [tqa_pkg::COORD_BITS-1:0] cy,
    input  logic signed [tqa_pkg::COORD_BITS-1:0] cz,
    input  logic                                  last_triangle,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [tqa_pkg::AVG_W-1:0]             avg_ratio,
    output logic [tqa_pkg::AVG_W-1:0]             avg_weighted_ratio,
    output logic                                  zero_area,
    output logic [tqa_pkg::COUNT_BITS-1:0]        triangle_count,
    output logic                                  saturated
);
    import tqa_pkg::*;

    typedef enum logic [24:0] {
        S_IDLE      = 25'h0000001,
        S_SQ_SETUP  = 25'h0000002,
        S_SQ_NEXT   = 25'h0000004,
        S_EDGE_DONE = 25'h0000008,
        S_FACT      = 25'h0000010,
        S_P12       = 25'h0000020,
        S_NUM       = 25'h0000040,
        S_AB        = 25'h0000080,
        S_DEN       = 25'h0000100,
        S_RATIO     = 25'h0000200,
        S_HS1       = 25'h0000400,
        S_HS2       = 25'h0000800,
        S_HS3       = 25'h0001000,
        S_HS4       = 25'h0002000,
        S_AREA      = 25'h0004000,
        S_WEIGHT    = 25'h0008000,
        S_ACCUM     = 25'h0010000,
        S_FIN1      = 25'h0020000,
        S_FIN2      = 25'h0040000,
        S_FIN3      = 25'h0080000,
        S_MUL_ISSUE = 25'h0100000,
        S_MUL_ADD   = 25'h0200000,
        S_SQRT      = 25'h0400000,
        S_DIV_CHK   = 25'h0800000,
        S_DIV_ITER  = 25'h1000000
    } state_t;

    // Control state
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   out_valid_reg, out_valid_next;

    // Mesh totals
    logic [RTOT_W-1:0]     rtot_reg, rtot_next;
    logic [WTOT_W-1:0]     wtot_reg, wtot_next;
    logic [ATOT_W-1:0]     atot_reg, atot_next;
    logic [COUNT_BITS-1:0] tcnt_reg, tcnt_next;
    logic                  sat_reg, sat_next;

    // Captured triangle
    logic signed [COORD_BITS-1:0] crd_reg [0:8];
    logic signed [COORD_BITS-1:0] crd_next [0:8];
    logic                         last_reg, last_next;

    // Sequencer working registers
    logic [1:0]        edge_reg, edge_next;
    logic [1:0]        axis_reg, axis_next;
    logic [1:0]        pp_reg, pp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [OPD_W-1:0]  mx_reg, mx_next;
    logic [OPD_W-1:0]  my_reg, my_next;
    logic [ACC_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [RES_W-1:0]  res_reg, res_next;
    logic [LOW_W-1:0]  low_reg, low_next;
    logic [DEN_W-1:0]  dvs_reg, dvs_next;
    logic [EDGE_W-1:0] ea_reg, ea_next;
    logic [EDGE_W-1:0] eb_reg, eb_next;
    logic [EDGE_W-1:0] ec_reg, ec_next;
    logic [FACT_W-1:0] f1_reg, f1_next;
    logic [FACT_W-1:0] f2_reg, f2_next;
    logic [FACT_W-1:0] f3_reg, f3_next;
    logic [FACT_W-1:0] sp_reg, sp_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [OPD_W-1:0]  t_reg, t_next;
    logic [AVG_W-1:0]  ratio_reg, ratio_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [AVG_W-1:0]  avgr_reg, avgr_next;
    logic              zarea_reg, zarea_next;

    // Output register
    logic [AVG_W-1:0]      o_avgr_reg, o_avgr_next;
    logic [AVG_W-1:0]      o_avgw_reg, o_avgw_next;
    logic                  o_zero_reg, o_zero_next;
    logic [COUNT_BITS-1:0] o_cnt_reg, o_cnt_next;
    logic                  o_sat_reg, o_sat_next;

    // Shared units
    logic [HALF_W-1:0] mul_x, mul_y;
    logic [PROD_W-1:0] prod_reg;
    addsub_req_t       as_req;
    addsub_rsp_t       as_rsp;

    // Combinational helpers
    logic [1:0]               pv, qv;
    logic [3:0]               p_idx, q_idx;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        absd;
    logic signed [FACT_W-1:0] f1_c, f2_c, f3_c;
    logic [FACT_W-1:0]        sp_c;
    logic                     f_pos;
    logic [ACC_W-1:0]         pp_shifted;
    logic [REM_W-1:0]         sq_cur, sq_trial, div_cur;
    logic [AVG_W-1:0]         div_q;
    logic [RTOT_W:0]          r_sum;
    logic [WTOT_W:0]          w_sum;
    logic [ATOT_W:0]          a_sum;
    logic [COUNT_BITS:0]      c_sum;

    tqa_mul u_mul (
        .clk      (clk),
        .x        (mul_x),
        .y        (mul_y),
        .prod_reg (prod_reg)
    );

    tqa_addsub u_addsub (
        .req (as_req),
        .rsp (as_rsp)
    );

    assign in_stall = (state_reg != S_IDLE);

    // Endpoints of the current edge: a = v1-v2, b = v0-v2, c = v0-v1
    always_comb
    begin
        case (edge_reg)
            2'd0:    begin pv = 2'd1; qv = 2'd2; end
            2'd1:    begin pv = 2'd0; qv = 2'd2; end
            default: begin pv = 2'd0; qv = 2'd1; end
        endcase
    end

    assign p_idx = 4'({2'b00, pv} * 4'd3 + {2'b00, axis_reg});
    assign q_idx = 4'({2'b00, qv} * 4'd3 + {2'b00, axis_reg});
    assign diff  = DIFF_W'(crd_reg[p_idx]) - DIFF_W'(crd_reg[q_idx]);
    assign absd  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // Heron factors and perimeter
    assign f1_c  = FACT_W'(ea_reg) + FACT_W'(eb_reg) - FACT_W'(ec_reg);
    assign f2_c  = FACT_W'(eb_reg) + FACT_W'(ec_reg) - FACT_W'(ea_reg);
    assign f3_c  = FACT_W'(ec_reg) + FACT_W'(ea_reg) - FACT_W'(eb_reg);
    assign sp_c  = FACT_W'(ea_reg) + FACT_W'(eb_reg) + FACT_W'(ec_reg);
    assign f_pos = (f1_c > 0) && (f2_c > 0) && (f3_c > 0);

    // Multiplier operand halves: pp[1] picks x half, pp[0] picks y half
    assign mul_x = pp_reg[1] ? mx_reg[OPD_W-1:HALF_W] : mx_reg[HALF_W-1:0];
    assign mul_y = pp_reg[0] ? my_reg[OPD_W-1:HALF_W] : my_reg[HALF_W-1:0];

    // Partial product alignment
    always_comb
    begin
        case (pp_reg) inside
            2'd0:       pp_shifted = {{(ACC_W-PROD_W){1'b0}}, prod_reg};
            2'd1, 2'd2: pp_shifted = {{(ACC_W-PROD_W-HALF_W){1'b0}}, prod_reg,
                                      {HALF_W{1'b0}}};
            default:    pp_shifted = {prod_reg, {(ACC_W-PROD_W){1'b0}}};
        endcase
    end

    // Root and divide step operands
    assign sq_cur   = {rem_reg[REM_W-3:0], rad_reg[ACC_W-1:ACC_W-2]};
    assign sq_trial = {{(REM_W-RES_W-2){1'b0}}, res_reg, 2'b01};
    assign div_cur  = {rem_reg[REM_W-2:0], low_reg[LOW_W-1]};
    assign div_q    = (res_reg[AVG_W-1:0] > RATIO_ONE) ? RATIO_ONE : res_reg[AVG_W-1:0];

    // Shared add/subtract operand select
    always_comb
    begin
        as_req = '0;
        unique case (state_reg)
            S_MUL_ADD:
            begin
                as_req.a   = acc_reg;
                as_req.b   = pp_shifted;
                as_req.sub = 1'b0;
            end
            S_SQRT:
            begin
                as_req.a   = ACC_W'(sq_cur);
                as_req.b   = ACC_W'(sq_trial);
                as_req.sub = 1'b1;
            end
            S_DIV_CHK:
            begin
                as_req.a   = ACC_W'(rem_reg);
                as_req.b   = ACC_W'(dvs_reg);
                as_req.sub = 1'b1;
            end
            S_DIV_ITER:
            begin
                as_req.a   = ACC_W'(div_cur);
                as_req.b   = ACC_W'(dvs_reg);
                as_req.sub = 1'b1;
            end
            default:
            begin
                as_req = '0;
            end
        endcase
    end

    // Saturating accumulate sums
    assign r_sum = {1'b0, rtot_reg} + {{(RTOT_W+1-AVG_W){1'b0}}, ratio_reg};
    assign w_sum = {1'b0, wtot_reg} + {1'b0, acc_reg[WTOT_W-1:0]};
    assign a_sum = {1'b0, atot_reg} + {{(ATOT_W+1-AREA_W){1'b0}}, area_reg};
    assign c_sum = {1'b0, tcnt_reg} + {{COUNT_BITS{1'b0}}, 1'b1};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        out_valid_next = out_valid_reg;
        rtot_next      = rtot_reg;
        wtot_next      = wtot_reg;
        atot_next      = atot_reg;
        tcnt_next      = tcnt_reg;
        sat_next       = sat_reg;
        crd_next       = crd_reg;
        last_next      = last_reg;
        edge_next      = edge_reg;
        axis_next      = axis_reg;
        pp_next        = pp_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        low_next       = low_reg;
        dvs_next       = dvs_reg;
        ea_next        = ea_reg;
        eb_next        = eb_reg;
        ec_next        = ec_reg;
        f1_next        = f1_reg;
        f2_next        = f2_reg;
        f3_next        = f3_reg;
        sp_next        = sp_reg;
        num_next       = num_reg;
        t_next         = t_reg;
        ratio_next     = ratio_reg;
        area_next      = area_reg;
        avgr_next      = avgr_reg;
        zarea_next     = zarea_reg;
        o_avgr_next    = o_avgr_reg;
        o_avgw_next    = o_avgw_reg;
        o_zero_next    = o_zero_reg;
        o_cnt_next     = o_cnt_reg;
        o_sat_next     = o_sat_reg;

        // Result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    crd_next[0] = ax;
                    crd_next[1] = ay;
                    crd_next[2] = az;
                    crd_next[3] = bx;
                    crd_next[4] = by_coord;
                    crd_next[5] = bz;
                    crd_next[6] = cx;
                    crd_next[7] = cy;
                    crd_next[8] = cz;
                    last_next   = last_triangle;
                    edge_next   = 2'd0;
                    axis_next   = 2'd0;
                    state_next  = S_SQ_SETUP;
                end
            end

            // Square one coordinate difference into the edge sum
            S_SQ_SETUP:
            begin
                if (axis_reg == 2'd0)
                begin
                    acc_next = '0;
                end
                mx_next    = OPD_W'(absd);
                my_next    = OPD_W'(absd);
                pp_next    = 2'd0;
                ret_next   = S_SQ_NEXT;
                state_next = S_MUL_ISSUE;
            end

            S_SQ_NEXT:
            begin
                if (axis_reg == 2'd2)
                begin
                    rad_next   = {acc_reg[ACC_W-55:0], 54'd0};
                    rem_next   = '0;
                    res_next   = '0;
                    cnt_next   = EDGE_ROOT_STEPS;
                    ret_next   = S_EDGE_DONE;
                    state_next = S_SQRT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_SQ_SETUP;
                end
            end

            S_EDGE_DONE:
            begin
                case (edge_reg)
                    2'd0:    ea_next = res_reg[EDGE_W-1:0];
                    2'd1:    eb_next = res_reg[EDGE_W-1:0];
                    default: ec_next = res_reg[EDGE_W-1:0];
                endcase
                if (edge_reg == 2'd2)
                begin
                    state_next = S_FACT;
                end
                else
                begin
                    edge_next  = edge_reg + 2'd1;
                    axis_next  = 2'd0;
                    state_next = S_SQ_SETUP;
                end
            end

            // Heron factors; non-positive factor gives zero ratio and area
            S_FACT:
            begin
                f1_next = f1_c;
                f2_next = f2_c;
                f3_next = f3_c;
                sp_next = sp_c;
                if (f_pos)
                begin
                    acc_next   = '0;
                    mx_next    = OPD_W'(f1_c);
                    my_next    = OPD_W'(f2_c);
                    pp_next    = 2'd0;
                    ret_next   = S_P12;
                    state_next = S_MUL_ISSUE;
                end
                else
                begin
                    ratio_next = '0;
                    area_next  = '0;
                    state_next = S_WEIGHT;
                end
            end

            S_P12:
            begin
                acc_next   = '0;
                mx_next    = acc_reg[OPD_W-1:0];
                my_next    = OPD_W'(f3_reg);
                pp_next    = 2'd0;
                ret_next   = S_NUM;
                state_next = S_MUL_ISSUE;
            end

            S_NUM:
            begin
                num_next   = acc_reg[NUM_W-1:0];
                acc_next   = '0;
                mx_next    = OPD_W'(ea_reg);
                my_next    = OPD_W'(eb_reg);
                pp_next    = 2'd0;
                ret_next   = S_AB;
                state_next = S_MUL_ISSUE;
            end

            S_AB:
            begin
                acc_next   = '0;
                mx_next    = acc_reg[OPD_W-1:0];
                my_next    = OPD_W'(ec_reg);
                pp_next    = 2'd0;
                ret_next   = S_DEN;
                state_next = S_MUL_ISSUE;
            end

            // Ratio = clamp(num * 2^16 / abc); zero when abc is zero
            S_DEN:
            begin
                if (acc_reg[DEN_W-1:0] == '0)
                begin
                    ratio_next = '0;
                    state_next = S_HS1;
                end
                else
                begin
                    rem_next   = num_reg[NUM_W-1:1];
                    low_next   = {num_reg[0], 16'd0};
                    dvs_next   = acc_reg[DEN_W-1:0];
                    res_next   = '0;
                    ret_next   = S_RATIO;
                    state_next = S_DIV_CHK;
                end
            end

            S_RATIO:
            begin
                ratio_next = div_q;
                state_next = S_HS1;
            end

            // Heron product (a+b+c) * f1 * f2 * f3
            S_HS1:
            begin
                acc_next   = '0;
                mx_next    = OPD_W'(sp_reg);
                my_next    = OPD_W'(f1_reg);
                pp_next    = 2'd0;
                ret_next   = S_HS2;
                state_next = S_MUL_ISSUE;
            end

            S_HS2:
            begin
                t_next     = acc_reg[OPD_W-1:0];
                acc_next   = '0;
                mx_next    = OPD_W'(f2_reg);
                my_next    = OPD_W'(f3_reg);
                pp_next    = 2'd0;
                ret_next   = S_HS3;
                state_next = S_MUL_ISSUE;
            end

            S_HS3:
            begin
                acc_next   = '0;
                mx_next    = t_reg;
                my_next    = acc_reg[OPD_W-1:0];
                pp_next    = 2'd0;
                ret_next   = S_HS4;
                state_next = S_MUL_ISSUE;
            end

            S_HS4:
            begin
                rad_next   = {acc_reg[ACC_W-7:0], 6'd0};
                rem_next   = '0;
                res_next   = '0;
                cnt_next   = AREA_ROOT_STEPS;
                ret_next   = S_AREA;
                state_next = S_SQRT;
            end

            S_AREA:
            begin
                area_next  = res_reg[AREA_W+1:2];
                state_next = S_WEIGHT;
            end

            S_WEIGHT:
            begin
                acc_next   = '0;
                mx_next    = OPD_W'(ratio_reg);
                my_next    = OPD_W'(area_reg);
                pp_next    = 2'd0;
                ret_next   = S_ACCUM;
                state_next = S_MUL_ISSUE;
            end

            // Saturating update of the mesh totals
            S_ACCUM:
            begin
                rtot_next = r_sum[RTOT_W] ? {RTOT_W{1'b1}} : r_sum[RTOT_W-1:0];
                wtot_next = w_sum[WTOT_W] ? {WTOT_W{1'b1}} : w_sum[WTOT_W-1:0];
                atot_next = a_sum[ATOT_W] ? {ATOT_W{1'b1}} : a_sum[ATOT_W-1:0];
                tcnt_next = c_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}}
                                              : c_sum[COUNT_BITS-1:0];
                sat_next  = sat_reg | r_sum[RTOT_W] | w_sum[WTOT_W] | a_sum[ATOT_W]
                            | c_sum[COUNT_BITS];
                state_next = last_reg ? S_FIN1 : S_IDLE;
            end

            // Mean ratio
            S_FIN1:
            begin
                rem_next   = REM_W'(rtot_reg >> LOW_W);
                low_next   = rtot_reg[LOW_W-1:0];
                dvs_next   = DEN_W'(tcnt_reg);
                res_next   = '0;
                ret_next   = S_FIN2;
                state_next = S_DIV_CHK;
            end

            // Area-weighted mean, skipped for zero total area
            S_FIN2:
            begin
                avgr_next = div_q;
                if (atot_reg == '0)
                begin
                    zarea_next = 1'b1;
                    state_next = S_FIN3;
                end
                else
                begin
                    zarea_next = 1'b0;
                    rem_next   = REM_W'(wtot_reg >> LOW_W);
                    low_next   = wtot_reg[LOW_W-1:0];
                    dvs_next   = atot_reg;
                    res_next   = '0;
                    ret_next   = S_FIN3;
                    state_next = S_DIV_CHK;
                end
            end

            // Load the output register once it is free, then clear totals
            S_FIN3:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    o_avgr_next    = avgr_reg;
                    o_avgw_next    = zarea_reg ? '0 : div_q;
                    o_zero_next    = zarea_reg;
                    o_cnt_next     = tcnt_reg;
                    o_sat_next     = sat_reg;
                    out_valid_next = 1'b1;
                    rtot_next      = '0;
                    wtot_next      = '0;
                    atot_next      = '0;
                    tcnt_next      = '0;
                    sat_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            // Wide multiply: issue one partial product
            S_MUL_ISSUE:
            begin
                state_next = S_MUL_ADD;
            end

            // Wide multiply: add the aligned partial product
            S_MUL_ADD:
            begin
                acc_next = as_rsp.sum;
                if (pp_reg == 2'd3)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    pp_next    = pp_reg + 2'd1;
                    state_next = S_MUL_ISSUE;
                end
            end

            // Restoring square root, one root bit per cycle
            S_SQRT:
            begin
                if (!as_rsp.borrow)
                begin
                    rem_next = as_rsp.sum[REM_W-1:0];
                    res_next = {res_reg[RES_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = sq_cur;
                    res_next = {res_reg[RES_W-2:0], 1'b0};
                end
                rad_next = {rad_reg[ACC_W-3:0], 2'b00};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = ret_reg;
                end
            end

            // Quotient of 2^17 or more clamps straight to one
            S_DIV_CHK:
            begin
                if (!as_rsp.borrow)
                begin
                    res_next   = RES_W'(RATIO_ONE);
                    state_next = ret_reg;
                end
                else
                begin
                    cnt_next   = DIV_STEPS;
                    state_next = S_DIV_ITER;
                end
            end

            // Restoring divide, one quotient bit per cycle
            S_DIV_ITER:
            begin
                if (!as_rsp.borrow)
                begin
                    rem_next = as_rsp.sum[REM_W-1:0];
                    res_next = {res_reg[RES_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_cur;
                    res_next = {res_reg[RES_W-2:0], 1'b0};
                end
                low_next = {low_reg[LOW_W-2:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
            rtot_reg      <= '0;
            wtot_reg      <= '0;
            atot_reg      <= '0;
            tcnt_reg      <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            rtot_reg      <= rtot_next;
            wtot_reg      <= wtot_next;
            atot_reg      <= atot_next;
            tcnt_reg      <= tcnt_next;
            sat_reg       <= sat_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        crd_reg     <= crd_next;
        last_reg    <= last_next;
        edge_reg    <= edge_next;
        axis_reg    <= axis_next;
        pp_reg      <= pp_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        rad_reg     <= rad_next;
        rem_reg     <= rem_next;
        res_reg     <= res_next;
        low_reg     <= low_next;
        dvs_reg     <= dvs_next;
        ea_reg      <= ea_next;
        eb_reg      <= eb_next;
        ec_reg      <= ec_next;
        f1_reg      <= f1_next;
        f2_reg      <= f2_next;
        f3_reg      <= f3_next;
        sp_reg      <= sp_next;
        num_reg     <= num_next;
        t_reg       <= t_next;
        ratio_reg   <= ratio_next;
        area_reg    <= area_next;
        avgr_reg    <= avgr_next;
        zarea_reg   <= zarea_next;
        o_avgr_reg  <= o_avgr_next;
        o_avgw_reg  <= o_avgw_next;
        o_zero_reg  <= o_zero_next;
        o_cnt_reg   <= o_cnt_next;
        o_sat_reg   <= o_sat_next;
    end

    assign out_valid          = out_valid_reg;
    assign avg_ratio          = o_avgr_reg;
    assign avg_weighted_ratio = o_avgw_reg;
    assign zero_area          = o_zero_reg;
    assign triangle_count     = o_cnt_reg;
    assign saturated          = o_sat_reg;

endmodule

`default_nettype wire

### verif/tb_triangle_quality_averager.sv
// ----------------------------------------------------------------------------
// tb_triangle_quality_averager
// Self-checking bench for the triangle quality averager. Triangles are sent
// over the valid/stall input channel, and a bit-exact model in the scoreboard
// predicts the mesh statistics emitted on each last triangle. Results are
// compared field by field in order under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import tqa_pkg::*;

typedef struct {
    logic signed [COORD_BITS-1:0] v[9];
    logic                         last;
} triangle_t;

typedef struct {
    logic [AVG_W-1:0]      avg_ratio;
    logic [AVG_W-1:0]      avg_weighted;
    logic                  zero_area;
    logic [COUNT_BITS-1:0] count;
    logic                  sat;
} mesh_stats_t;

class mesh_scoreboard;
    mesh_stats_t pending[$];
    logic [63:0] ratio_sum, weighted_sum, area_sum, tri_count;
    bit          sat_seen;
    int          mismatches;
    int          results_seen;
    int          triangles_seen;

    function new();
        clear_totals();
        mismatches = 0;
        results_seen = 0;
        triangles_seen = 0;
    endfunction

    function void clear_totals();
        ratio_sum = 0;
        weighted_sum = 0;
        area_sum = 0;
        tri_count = 0;
        sat_seen = 0;
    endfunction

    // floor square root, trial bits from top down
    function logic [63:0] floor_root(logic [127:0] val, int top);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int i = top; i >= 0; i--) begin
            c = r | (128'd1 << i);
            if (c * c <= val)
                r = c;
        end
        return r[63:0];
    endfunction

    function logic [63:0] edge_length(longint x0, longint y0, longint z0,
                                      longint x1, longint y1, longint z1);
        longint      d[3];
        logic [63:0] m;
        logic [63:0] sum;
        d[0] = x0 - x1;
        d[1] = y0 - y1;
        d[2] = z0 - z1;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m = (d[i] < 0) ? -d[i] : d[i];
            sum += m * m;
        end
        return floor_root({64'd0, sum}, 31);
    endfunction

    function logic [63:0] sat_add(logic [63:0] acc, logic [63:0] v, logic [63:0] max);
        if (acc > max || v > max - acc) begin
            sat_seen = 1;
            return max;
        end
        return acc + v;
    endfunction

    // accepted triangle: update totals, queue stats on the last one
    function void note_triangle(triangle_t t);
        longint      p[9];
        logic [63:0] ea, eb, ec, u1, u2, u3, den, p12, num, rem, quo;
        logic [63:0] ratio, area, weighted, x, y;
        longint      f1, f2, f3;
        mesh_stats_t s;
        triangles_seen++;
        for (int i = 0; i < 9; i++)
            p[i] = longint'(t.v[i]);
        ea = edge_length(p[3], p[4], p[5], p[6], p[7], p[8]);
        eb = edge_length(p[0], p[1], p[2], p[6], p[7], p[8]);
        ec = edge_length(p[0], p[1], p[2], p[3], p[4], p[5]);
        f1 = longint'(ea) + longint'(eb) - longint'(ec);
        f2 = longint'(eb) + longint'(ec) - longint'(ea);
        f3 = longint'(ec) + longint'(ea) - longint'(eb);
        ratio = 0;
        area = 0;
        if (f1 > 0 && f2 > 0 && f3 > 0) begin
            u1 = f1;
            u2 = f2;
            u3 = f3;
            den = ea * eb * ec;
            p12 = u1 * u2;
            if (den != 0) begin
                if (u3 > den / p12) begin
                    ratio = 64'(RATIO_ONE);
                end else begin
                    num = p12 * u3;
                    if (num >= den) begin
                        ratio = 64'(RATIO_ONE);
                    end else begin
                        rem = num;
                        quo = 0;
                        for (int i = 0; i < 16; i++) begin
                            rem = rem << 1;
                            quo = quo << 1;
                            if (rem >= den) begin
                                rem -= den;
                                quo[0] = 1'b1;
                            end
                        end
                        ratio = quo;
                    end
                end
            end
            x = (ea + eb + ec) * u1;
            y = u2 * u3;
            area = floor_root({64'd0, x} * {64'd0, y}, 63) >> 2;
        end
        if (area != 0 && ratio > 64'hFFFF_FFFF_FFFF_FFFF / area) begin
            weighted = 64'hFFFF_FFFF_FFFF_FFFF;
            sat_seen = 1;
        end else begin
            weighted = ratio * area;
        end
        ratio_sum    = sat_add(ratio_sum, ratio, (64'd1 << RTOT_W) - 1);
        weighted_sum = sat_add(weighted_sum, weighted, 64'hFFFF_FFFF_FFFF_FFFF);
        area_sum     = sat_add(area_sum, area, 64'hFFFF_FFFF_FFFF_FFFF);
        tri_count    = sat_add(tri_count, 64'd1, (64'd1 << COUNT_BITS) - 1);
        if (!t.last)
            return;
        s.avg_ratio = 0;
        if (tri_count != 0)
            s.avg_ratio = (ratio_sum / tri_count > RATIO_ONE) ? RATIO_ONE
                                                              : AVG_W'(ratio_sum / tri_count);
        s.avg_weighted = 0;
        if (area_sum != 0)
            s.avg_weighted = (weighted_sum / area_sum > RATIO_ONE) ? RATIO_ONE
                                                                   : AVG_W'(weighted_sum / area_sum);
        s.zero_area = (area_sum == 0);
        s.count     = tri_count[COUNT_BITS-1:0];
        s.sat       = sat_seen;
        pending.insert(pending.size(), s);
        clear_totals();
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_stats(mesh_stats_t got);
        mesh_stats_t want;
        results_seen++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: ratio %0d weighted %0d count %0d",
                         got.avg_ratio, got.avg_weighted, got.count);
            return;
        end
        want = pending.pop_front();
        if (got.avg_ratio !== want.avg_ratio || got.avg_weighted !== want.avg_weighted ||
            got.zero_area !== want.zero_area || got.count !== want.count ||
            got.sat !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch #%0d: exp r=%0d w=%0d z=%0d n=%0d s=%0d, got r=%0d w=%0d z=%0d n=%0d s=%0d",
                         results_seen, want.avg_ratio, want.avg_weighted, want.zero_area,
                         want.count, want.sat, got.avg_ratio, got.avg_weighted,
                         got.zero_area, got.count, got.sat);
        end
    endfunction
endclass

module tb_triangle_quality_averager;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam longint CMAX = 524287;
    localparam longint CMIN = -524288;

    logic                         clk = 0;
    logic                         rst_n = 0;
    logic                         in_valid = 0;
    logic                         in_stall;
    logic signed [COORD_BITS-1:0] coord[9];
    logic                         last_triangle = 0;
    logic                         out_valid;
    logic                         out_stall = 0;
    logic [AVG_W-1:0]             avg_ratio;
    logic [AVG_W-1:0]             avg_weighted_ratio;
    logic                         zero_area;
    logic [COUNT_BITS-1:0]        triangle_count;
    logic                         saturated;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles = 0;

    mesh_scoreboard sb = new();

    triangle_quality_averager uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .ax(coord[0]), .ay(coord[1]), .az(coord[2]),
        .bx(coord[3]), .by_coord(coord[4]), .bz(coord[5]),
        .cx(coord[6]), .cy(coord[7]), .cz(coord[8]),
        .last_triangle(last_triangle),
        .out_valid(out_valid), .out_stall(out_stall),
        .avg_ratio(avg_ratio), .avg_weighted_ratio(avg_weighted_ratio),
        .zero_area(zero_area), .triangle_count(triangle_count),
        .saturated(saturated)
    );

    initial
    begin
        for (int i = 0; i < 9; i++)
            coord[i] = 0;
    end

    always #4 clk = ~clk;

    // cycle watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        mesh_stats_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.avg_ratio    = avg_ratio;
            got.avg_weighted = avg_weighted_ratio;
            got.zero_area    = zero_area;
            got.count        = triangle_count;
            got.sat          = saturated;
            sb.check_stats(got);
        end
    end

    // one transaction on the input channel, with optional idle cycles first
    task automatic send_triangle(triangle_t t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        for (int i = 0; i < 9; i++)
            coord[i] <= t.v[i];
        last_triangle <= t.last;
        in_valid <= 1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_triangle(t);
    endtask

    function automatic longint clamp_coord(longint v);
        return (v > CMAX) ? CMAX : (v < CMIN) ? CMIN : v;
    endfunction

    function automatic triangle_t make_triangle(longint p0, longint p1, longint p2,
                                                longint p3, longint p4, longint p5,
                                                longint p6, longint p7, longint p8,
                                                bit last);
        triangle_t t;
        t.v[0] = COORD_BITS'(p0); t.v[1] = COORD_BITS'(p1); t.v[2] = COORD_BITS'(p2);
        t.v[3] = COORD_BITS'(p3); t.v[4] = COORD_BITS'(p4); t.v[5] = COORD_BITS'(p5);
        t.v[6] = COORD_BITS'(p6); t.v[7] = COORD_BITS'(p7); t.v[8] = COORD_BITS'(p8);
        t.last = last;
        return t;
    endfunction

    // random triangle: mostly local meshes of varied scale, some wide or degenerate
    function automatic triangle_t random_triangle();
        triangle_t t;
        int        kind;
        longint    span;
        longint    center[3];
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: span = 8;
            1: span = 256;
            2: span = 8192;
            default: span = 200000;
        endcase
        for (int k = 0; k < 3; k++)
            center[k] = longint'($urandom_range(0, 1048575)) - 524288;
        for (int i = 0; i < 9; i++) begin
            if (kind < 20)
                t.v[i] = COORD_BITS'($urandom());
            else
                t.v[i] = COORD_BITS'(clamp_coord(center[i % 3] +
                                     longint'($urandom_range(0, 2 * span)) - span));
        end
        // degenerate: repeated or collinear vertex
        if (kind >= 85 && kind < 93) begin
            for (int k = 0; k < 3; k++)
                t.v[6 + k] = t.v[k];
        end else if (kind >= 93) begin
            for (int k = 0; k < 3; k++)
                t.v[6 + k] = COORD_BITS'((longint'(t.v[k]) + longint'(t.v[3 + k])) / 2);
        end
        t.last = ($urandom_range(0, 7) == 0);
        return t;
    endfunction

    initial
    begin
        triangle_t dir[$];
        int        phase_items;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, degenerate shapes, single-triangle meshes
        dir.insert(dir.size(), make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        dir.insert(dir.size(), make_triangle(0, 0, 0, 256, 0, 0, 128, 222, 0, 1));
        dir.insert(dir.size(), make_triangle(0, 0, 0, 25600, 0, 0, 12800, 22170, 0, 0));
        dir.insert(dir.size(), make_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0, 0));
        dir.insert(dir.size(), make_triangle(0, 0, 0, 100, 0, 0, 200, 0, 0, 1));
        dir.insert(dir.size(), make_triangle(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                                             CMIN, CMAX, CMIN, 0));
        dir.insert(dir.size(), make_triangle(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN,
                                             CMAX, CMAX, CMIN, 0));
        dir.insert(dir.size(), make_triangle(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                                             CMIN, CMIN, CMIN, 1));
        dir.insert(dir.size(), make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0, 1));
        dir.insert(dir.size(), make_triangle(0, 0, 0, 1, 0, 0, 1, 1, 0, 0));
        dir.insert(dir.size(), make_triangle(0, 0, 0, 3, 0, 0, 1, 1, 0, 0));
        dir.insert(dir.size(), make_triangle(-5, -5, -5, -5, -5, -5, 7, 7, 7, 1));
        dir.insert(dir.size(), make_triangle(0, 0, 0, 100000, 0, 0, 50000, 1, 0, 1));
        dir.insert(dir.size(), make_triangle(CMAX, 0, 0, CMIN, 0, 0, 0, CMAX, 0, 1));
        dir.insert(dir.size(), make_triangle(-1, -1, -1, 0, 0, 0, -1, 0, -1, 1));
        send_idle_pct = 15;
        recv_idle_pct = 57;
        foreach (dir[i])
            send_triangle(dir[i]);

        // random meshes over three idling profiles
        phase_items = 180;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 57 : 0;
            recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 15 : 0;
            for (int n = 0; n < phase_items; n++)
                send_triangle(random_triangle());
        end
        // close the last open mesh
        send_triangle(make_triangle(0, 0, 0, 512, 0, 0, 0, 512, 0, 1));
        in_valid <= 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        $display("Covered %0d triangles, %0d mesh results checked, %0d mismatches.",
                 sb.triangles_seen, sb.results_seen, sb.mismatches);
        $display("Idling profiles: sender-light, receiver-light, and back-to-back.");
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
